[rtl/dros_pkg.sv]
// Shared types, constants and helpers for the DHCP reply option scanner.
// Standalone package; every rtl/dros_* module and the top level refer to it.
package dros_pkg;

    localparam int unsigned OFFSET_W  = 11;
    localparam int unsigned RESULT_W  = 138;
    localparam int unsigned M_TDATA_W = 144;
    localparam int unsigned APB_AW    = 3;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 11'd2047;
    localparam logic [OFFSET_W-1:0] OPT_START  = 11'd240;
    localparam logic [OFFSET_W-1:0] XID_FIRST  = 11'd4;
    localparam logic [OFFSET_W-1:0] XID_LAST   = 11'd7;
    localparam logic [OFFSET_W-1:0] YIP_FIRST  = 11'd16;
    localparam logic [OFFSET_W-1:0] YIP_LAST   = 11'd19;

    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_END     = 8'd255;
    localparam logic [7:0] OPT_MASK    = 8'd1;
    localparam logic [7:0] OPT_ROUTER  = 8'd3;
    localparam logic [7:0] OPT_MSGTYPE = 8'd53;

    localparam logic [7:0] LOOKUP_KEY_RST = 8'd54;

    // register index taken from paddr[2]
    localparam logic REG_CLIENT_XID = 1'b0;
    localparam logic REG_LOOKUP_KEY = 1'b1;

    typedef struct packed {
        logic accept;   // item taken this cycle
        logic last;     // final byte of the message
        logic in_opts;  // offset lies in the option area
    } t_byte_ctl;

    typedef struct packed {
        logic        xid_match;
        logic [7:0]  msg_type;
        logic [31:0] offered_ip;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic        key_found;
        logic [31:0] key_value;
    } t_result;

    // big-endian placement of one byte into a 32-bit word
    function automatic logic [31:0] place(input logic [7:0] b, input logic [1:0] idx);
        logic [31:0] w;
        case (idx)
            2'd0:    w = {b, 24'h0};
            2'd1:    w = {8'h0, b, 16'h0};
            2'd2:    w = {16'h0, b, 8'h0};
            default: w = {24'h0, b};
        endcase
        return w;
    endfunction

endpackage

[rtl/dros_hdr.sv]
// Byte offset counter and fixed-header capture (transaction ID, your-IP).
// Depends on dros_pkg.
module dros_hdr #(
    parameter int unsigned MAX_MSG_BYTES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output dros_pkg::t_byte_ctl     o_ctl,
    output logic [31:0]             o_xid,
    output logic [31:0]             o_offered
);

    localparam logic [dros_pkg::OFFSET_W:0] OPT_LIMIT =
        (dros_pkg::OFFSET_W + 1)'(MAX_MSG_BYTES);

    logic [dros_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [31:0] r_xid, n_xid;
    logic [31:0] r_offered, n_offered;

    always_comb begin
        n_xid     = r_xid;
        n_offered = r_offered;
        if (r_offset >= dros_pkg::XID_FIRST && r_offset <= dros_pkg::XID_LAST) begin
            n_xid = r_xid | dros_pkg::place(i_byte, r_offset[1:0]);
        end
        if (r_offset >= dros_pkg::YIP_FIRST && r_offset <= dros_pkg::YIP_LAST) begin
            n_offered = r_offered | dros_pkg::place(i_byte, r_offset[1:0]);
        end
        n_offset = (r_offset < dros_pkg::OFFSET_MAX) ? r_offset + 1'b1 : r_offset;
    end

    assign o_ctl.accept  = i_accept;
    assign o_ctl.last    = i_last;
    assign o_ctl.in_opts = (r_offset >= dros_pkg::OPT_START) && ({1'b0, r_offset} < OPT_LIMIT);
    assign o_xid         = n_xid;
    assign o_offered     = n_offered;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_xid     <= '0;
            r_offered <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_offset  <= '0;
                r_xid     <= '0;
                r_offered <= '0;
            end else begin
                r_offset  <= n_offset;
                r_xid     <= n_xid;
                r_offered <= n_offered;
            end
        end
    end

endmodule

[rtl/dros_tlv.sv]
// Option walker: code/length/value phases and the captured option values.
// Depends on dros_pkg; driven by the control struct from dros_hdr.
module dros_tlv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dros_pkg::t_byte_ctl i_ctl,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_lookup_key,
    output logic [7:0]          o_msg_type,
    output logic [31:0]         o_subnet_mask,
    output logic [31:0]         o_router_addr,
    output logic                o_key_found,
    output logic [31:0]         o_key_value
);

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_remaining, n_remaining;
    logic [2:0]  r_index, n_index;     // saturates at 4: only the first four bytes count
    logic [7:0]  r_type, n_type;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_router, n_router;
    logic        r_key_seen, n_key_seen;
    logic [31:0] r_key_reg, n_key_reg;
    logic        r_key_active, n_key_active;
    logic [31:0] w_placed;

    assign w_placed = dros_pkg::place(i_byte, r_index[1:0]);

    always_comb begin
        n_phase      = r_phase;
        n_code       = r_code;
        n_remaining  = r_remaining;
        n_index      = r_index;
        n_type       = r_type;
        n_mask       = r_mask;
        n_router     = r_router;
        n_key_seen   = r_key_seen;
        n_key_reg    = r_key_reg;
        n_key_active = r_key_active;
        if (i_ctl.accept && i_ctl.in_opts) begin
            case (r_phase)
                PH_LEN: begin
                    n_remaining = i_byte;
                    n_index     = '0;
                    n_phase     = (i_byte == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE: begin
                    if (!r_index[2]) begin
                        if (r_code == dros_pkg::OPT_MSGTYPE && r_index == 3'd0) begin
                            n_type = i_byte;
                        end
                        if (r_code == dros_pkg::OPT_MASK) begin
                            n_mask = r_mask | w_placed;
                        end
                        if (r_code == dros_pkg::OPT_ROUTER) begin
                            n_router = r_router | w_placed;
                        end
                        if (r_key_active) begin
                            n_key_reg = r_key_reg | w_placed;
                        end
                        n_index = r_index + 3'd1;
                    end
                    n_remaining = (r_remaining != 8'd0) ? r_remaining - 8'd1 : 8'd0;
                    if (n_remaining == 8'd0) begin
                        n_phase = PH_CODE;
                    end
                end
                default: begin
                    // code phase; pad and end are single bytes, a code on the last byte is dropped
                    if (!(i_byte == dros_pkg::OPT_PAD || i_byte == dros_pkg::OPT_END
                          || i_ctl.last)) begin
                        n_code       = i_byte;
                        n_key_active = 1'b0;
                        if (i_byte == dros_pkg::OPT_MSGTYPE) begin
                            n_type = '0;
                        end
                        if (i_byte == dros_pkg::OPT_MASK) begin
                            n_mask = '0;
                        end
                        if (i_byte == dros_pkg::OPT_ROUTER) begin
                            n_router = '0;
                        end
                        if (i_byte == i_lookup_key && !r_key_seen) begin
                            n_key_seen   = 1'b1;
                            n_key_reg    = '0;
                            n_key_active = 1'b1;
                        end
                        n_phase = PH_LEN;
                    end
                end
            endcase
        end
    end

    assign o_msg_type    = n_type;
    assign o_subnet_mask = n_mask;
    assign o_router_addr = n_router;
    assign o_key_found   = n_key_seen;
    assign o_key_value   = n_key_seen ? n_key_reg : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.accept && i_ctl.last)) begin
            r_phase      <= PH_CODE;
            r_code       <= '0;
            r_remaining  <= '0;
            r_index      <= '0;
            r_type       <= '0;
            r_mask       <= '0;
            r_router     <= '0;
            r_key_seen   <= 1'b0;
            r_key_reg    <= '0;
            r_key_active <= 1'b0;
        end else if (i_ctl.accept) begin
            r_phase      <= n_phase;
            r_code       <= n_code;
            r_remaining  <= n_remaining;
            r_index      <= n_index;
            r_type       <= n_type;
            r_mask       <= n_mask;
            r_router     <= n_router;
            r_key_seen   <= n_key_seen;
            r_key_reg    <= n_key_reg;
            r_key_active <= n_key_active;
        end
    end

endmodule

[rtl/dros_obuf.sv]
// Result register with one skid entry between the scanner and the output stream.
// Depends on dros_pkg (t_result).
module dros_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dros_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output dros_pkg::t_result o_data,
    input  logic              i_ready
);

    logic              r_out_valid;
    dros_pkg::t_result r_out_data;
    logic              r_skid_valid;
    dros_pkg::t_result r_skid_data;
    logic              w_pop;

    assign w_pop   = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_data  <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_from_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> $past(r_out_valid && !w_pop))
        else $error("skid entry filled without an output stall");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed while both entries full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_pop) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output register");

endmodule

[rtl/dhcp_reply_option_scanner_top.sv]
// Each result is registered as its last byte is taken, into the skid entry if m_axis stalls.
// Throughput: one byte per cycle; s_axis_tready drops only when both result entries are full.
// Rate is set by the combinational header/option update; the result path holds two results.
// Reset (i_rst_n low, synchronous) clears all per-message state and the result entries,
// and sets client_xid to 0 and lookup_key to 54. Depends on dros_pkg, dros_hdr, dros_tlv,
// dros_obuf.
module dhcp_reply_option_scanner_top #(
    parameter int unsigned MAX_MSG_BYTES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] msg_byte
    input  logic                              s_axis_tlast,  // last_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] xid_match, [8:1] msg_type, [40:9] offered_ip, [72:41] subnet_mask,
    // [104:73] router_addr, [105] key_found, [137:106] key_value, [143:138] zero
    output logic [dros_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dros_pkg::APB_AW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [31:0]         r_client_xid;
    logic [7:0]          r_lookup_key;
    logic                w_accept;
    dros_pkg::t_byte_ctl w_ctl;
    logic [31:0]         w_xid;
    logic [31:0]         w_offered;
    dros_pkg::t_result   w_res;
    dros_pkg::t_result   w_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_xid <= '0;
            r_lookup_key <= dros_pkg::LOOKUP_KEY_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                dros_pkg::REG_CLIENT_XID: r_client_xid <= pwdata;
                dros_pkg::REG_LOOKUP_KEY: r_lookup_key <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dros_pkg::REG_CLIENT_XID: prdata = r_client_xid;
            dros_pkg::REG_LOOKUP_KEY: prdata = {24'h0, r_lookup_key};
            default:                  prdata = '0;
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    dros_hdr #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_hdr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_ctl     (w_ctl),
        .o_xid     (w_xid),
        .o_offered (w_offered)
    );

    dros_tlv u_tlv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_byte        (s_axis_tdata),
        .i_lookup_key  (r_lookup_key),
        .o_msg_type    (w_res.msg_type),
        .o_subnet_mask (w_res.subnet_mask),
        .o_router_addr (w_res.router_addr),
        .o_key_found   (w_res.key_found),
        .o_key_value   (w_res.key_value)
    );

    assign w_res.xid_match  = (w_xid == r_client_xid);
    assign w_res.offered_ip = w_offered;

    dros_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && s_axis_tlast),
        .i_data  (w_res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {
        (dros_pkg::M_TDATA_W - dros_pkg::RESULT_W)'(0),
        w_out.key_value,
        w_out.key_found,
        w_out.router_addr,
        w_out.subnet_mask,
        w_out.offered_ip,
        w_out.msg_type,
        w_out.xid_match
    };

endmodule
